>>> sv/ilffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilffa_pkg
// shared types and constants for the implicit-list first-fit allocator
// ----------------------------------------------------------------------------
package ilffa_pkg;

    localparam int UNIT_BYTES = 8;
    localparam int UNIT_SHIFT = 3;
    localparam logic [UNIT_SHIFT-1:0] UNIT_MASK = 3'h7;
    localparam int REQ_W      = 14;
    localparam int OFF_W      = 13;
    localparam int STAT_W     = 2;
    localparam int NEED_W     = REQ_W + 1 - UNIT_SHIFT;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0]
    {
        STAT_OK       = 2'd0,
        STAT_OOM      = 2'd1,
        STAT_BAD_ADDR = 2'd2
    } stat_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_AWALK,
        S_SPLIT,
        S_FWALK,
        S_FTGT,
        S_FNEXT,
        S_FPRED,
        S_DONE
    } state_t;

    typedef struct packed
    {
        op_t              op;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] payload_offset;
    } req_t;

    typedef struct packed
    {
        stat_t            status;
        logic [OFF_W-1:0] granted_offset;
    } res_t;

    typedef struct packed
    {
        logic idle;
        logic done;
    } ctrl_st_t;

endpackage

>>> sv/implicit_list_first_fit_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// implicit_list_first_fit_allocator_core
// first-fit heap allocator over a header memory of 8-byte units
//
// channel   dir  tdata                                        tuser
// s_axis    in   request_bytes[13:0] payload_offset[26:14]      op
// m_axis    out  granted_offset[12:0] status[14:13]           -
//
// allocate: walks the block headers from the heap start, plus S_SPLIT when a block is split
// free: walks the blocks before the freed one, then S_FTGT, S_FNEXT and S_FPRED; S_FNEXT is skipped for the last block
// bad free address: answered from S_IDLE, or after a walk of the heap when not at a block start
// reset clears the state, the output valid flag and the heap top only; headers are written before they are read
// one request at a time; a finished result waits in the output register
// ----------------------------------------------------------------------------
module implicit_list_first_fit_allocator_core
    import ilffa_pkg::*;
#(
    parameter int HEAP_UNITS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // request_bytes, payload_offset
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // granted_offset, status
);

    localparam int AW = $clog2(HEAP_UNITS);
    localparam int SW = $clog2(HEAP_UNITS + 1);
    localparam int HDR_W = SW + 1;

    req_t             req;
    ctrl_st_t         ctrl_st;
    res_t             res;
    logic             start;
    logic             out_free;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [HDR_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [HDR_W-1:0] mem_rdata;
    logic             m_tvalid_reg, m_tvalid_next;
    res_t             m_res_reg, m_res_next;

    assign req.op             = op_t'(s_tuser);
    assign req.request_bytes  = s_tdata[REQ_W-1:0];
    assign req.payload_offset = s_tdata[REQ_W+OFF_W-1:REQ_W];

    assign s_tready = ctrl_st.idle;
    assign start    = s_tvalid && ctrl_st.idle;
    assign out_free = !m_tvalid_reg || m_tready;

    ilffa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HEAP_UNITS)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ilffa_ctrl #(
        .HEAP_UNITS (HEAP_UNITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .out_free  (out_free),
        .st        (ctrl_st),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        priority if (ctrl_st.done)
        begin
            m_tvalid_next = 1'b1;
            m_res_next    = res;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({m_res_reg.status, m_res_reg.granted_offset});

    // checks
    a_done_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_st.done |-> out_free)
        else $error("result produced while output slot busy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(ctrl_st.done))
        else $error("output valid without a finished request");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_res_reg.status == STAT_OK || m_res_reg.status == STAT_OOM
                      || m_res_reg.status == STAT_BAD_ADDR))
        else $error("undefined status code");

    a_no_grant_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_res_reg.status != STAT_OK) |-> (m_res_reg.granted_offset == '0))
        else $error("offset granted with error status");

endmodule

>>> sv/ilffa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilffa_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ilffa_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ilffa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilffa_ctrl
// header walker: reads one block header per cycle, splits, extends and merges
// ----------------------------------------------------------------------------
module ilffa_ctrl
    import ilffa_pkg::*;
#(
    parameter int HEAP_UNITS = 1024,
    localparam int AW = $clog2(HEAP_UNITS),
    localparam int SW = $clog2(HEAP_UNITS + 1),
    localparam int HDR_W = SW + 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  req_t             req,
    input  logic             out_free,
    output ctrl_st_t         st,
    output res_t             res,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output logic [HDR_W-1:0] mem_wdata,
    output logic [AW-1:0]    mem_raddr,
    input  logic [HDR_W-1:0] mem_rdata
);

    localparam int CW = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int TW = OFF_W - UNIT_SHIFT;

    function automatic logic [OFF_W-1:0] to_offset(input logic [SW-1:0] u);
        logic [SW:0]            u1;
        logic [SW+UNIT_SHIFT:0] b;
        u1 = {1'b0, u} + (SW+1)'(1);
        b  = {u1, {UNIT_SHIFT{1'b0}}};
        return OFF_W'(b);
    endfunction

    state_t            state_reg, state_next;
    logic [SW-1:0]     top_reg, top_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [SW-1:0]     t_reg, t_next;
    logic [SW-1:0]     prev_reg, prev_next;
    logic [SW-1:0]     prev_sz_reg, prev_sz_next;
    logic              prev_used_reg, prev_used_next;
    logic              has_pred_reg, has_pred_next;
    logic [SW-1:0]     tsize_reg, tsize_next;
    logic [SW-1:0]     split_addr_reg, split_addr_next;
    logic [SW-1:0]     split_sz_reg, split_sz_next;
    res_t              res_reg, res_next;

    logic [SW-1:0]     hdr_sz;
    logic              hdr_used;
    logic [SW:0]       step_sum;
    logic              step_end;
    logic              at_end;
    logic              fit;
    logic [CW-1:0]     rem;
    logic [CW-1:0]     ext_sum;
    logic              oom;
    logic              hit;
    logic [SW:0]       nn;
    logic              nn_end;
    logic [SW:0]       merged;
    logic [SW:0]       pred_sum;
    logic [REQ_W:0]    nsum;
    logic [NEED_W-1:0] need_in;
    logic              off_bad;
    logic [TW-1:0]     t_full;
    logic              t_out;

    // header decode and walk arithmetic
    always_comb
    begin
        hdr_sz   = mem_rdata[HDR_W-1:1];
        if (hdr_sz == '0)
        begin
            hdr_sz = SW'(1);
        end
        hdr_used = mem_rdata[0];
        step_sum = {1'b0, cur_reg} + {1'b0, hdr_sz};
        step_end = step_sum >= {1'b0, top_reg};
        at_end   = cur_reg >= top_reg;
        fit      = !hdr_used && (CW'(hdr_sz) >= CW'(need_reg));
        rem      = CW'(hdr_sz) - CW'(need_reg);
        ext_sum  = CW'(top_reg) + CW'(need_reg);
        oom      = ext_sum > CW'(HEAP_UNITS);
        hit      = step_sum == {1'b0, t_reg};
        nn       = {1'b0, t_reg} + {1'b0, hdr_sz};
        nn_end   = nn >= {1'b0, top_reg};
        merged   = hdr_used ? {1'b0, tsize_reg} : ({1'b0, tsize_reg} + {1'b0, hdr_sz});
        pred_sum = {1'b0, prev_sz_reg} + {1'b0, tsize_reg};
        nsum     = {1'b0, req.request_bytes} + (REQ_W+1)'(UNIT_BYTES + int'(UNIT_MASK));
        need_in  = nsum[REQ_W:UNIT_SHIFT];
        off_bad  = (req.payload_offset[OFF_W-1:UNIT_SHIFT] == '0)
                   || (req.payload_offset[UNIT_SHIFT-1:0] != '0);
        t_full   = req.payload_offset[OFF_W-1:UNIT_SHIFT] - TW'(1);
        t_out    = CW'(t_full) >= CW'(top_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.op == OP_ALLOC)
                    begin
                        state_next = S_AWALK;
                    end
                    else if (off_bad || t_out)
                    begin
                        state_next = S_DONE;
                    end
                    else if (t_full == '0)
                    begin
                        state_next = S_FTGT;
                    end
                    else
                    begin
                        state_next = S_FWALK;
                    end
                end
            end
            S_AWALK:
            begin
                priority if (at_end)
                begin
                    state_next = S_DONE;
                end
                else if (fit)
                begin
                    state_next = (rem <= CW'(1)) ? S_DONE : S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                state_next = S_DONE;
            end
            S_FWALK:
            begin
                priority if (hit)
                begin
                    state_next = S_FTGT;
                end
                else if (step_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_FTGT:
            begin
                state_next = nn_end ? S_FPRED : S_FNEXT;
            end
            S_FNEXT:
            begin
                state_next = S_FPRED;
            end
            S_FPRED:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        top_next        = top_reg;
        cur_next        = cur_reg;
        need_next       = need_reg;
        t_next          = t_reg;
        prev_next       = prev_reg;
        prev_sz_next    = prev_sz_reg;
        prev_used_next  = prev_used_reg;
        has_pred_next   = has_pred_reg;
        tsize_next      = tsize_reg;
        split_addr_next = split_addr_reg;
        split_sz_next   = split_sz_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;
        st.idle         = 1'b0;
        st.done         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                st.idle = 1'b1;
                if (start)
                begin
                    cur_next      = '0;
                    need_next     = need_in;
                    t_next        = SW'(t_full);
                    has_pred_next = t_full != '0;
                    res_next      = '{status: STAT_OK, granted_offset: '0};
                    if (req.op == OP_FREE && (off_bad || t_out))
                    begin
                        res_next.status = STAT_BAD_ADDR;
                    end
                end
            end
            S_AWALK:
            begin
                mem_raddr = step_sum[AW-1:0];
                priority if (at_end)
                begin
                    if (oom)
                    begin
                        res_next.status = STAT_OOM;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = top_reg[AW-1:0];
                        mem_wdata = {SW'(need_reg), 1'b1};
                        top_next  = SW'(ext_sum);
                        res_next.granted_offset = to_offset(top_reg);
                    end
                end
                else if (fit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg[AW-1:0];
                    res_next.granted_offset = to_offset(cur_reg);
                    if (rem <= CW'(1))
                    begin
                        mem_wdata = {hdr_sz, 1'b1};
                    end
                    else
                    begin
                        mem_wdata       = {SW'(need_reg), 1'b1};
                        split_addr_next = SW'(CW'(cur_reg) + CW'(need_reg));
                        split_sz_next   = SW'(rem);
                    end
                end
                else if (step_end)
                begin
                    cur_next = top_reg;
                end
                else
                begin
                    cur_next = step_sum[SW-1:0];
                end
            end
            S_SPLIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = split_addr_reg[AW-1:0];
                mem_wdata = {split_sz_reg, 1'b0};
            end
            S_FWALK:
            begin
                mem_raddr      = step_sum[AW-1:0];
                prev_next      = cur_reg;
                prev_sz_next   = hdr_sz;
                prev_used_next = hdr_used;
                if (!hit && step_end)
                begin
                    res_next.status = STAT_BAD_ADDR;
                end
                cur_next = step_sum[SW-1:0];
            end
            S_FTGT:
            begin
                mem_raddr  = nn[AW-1:0];
                tsize_next = hdr_sz;
                if (nn_end)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = t_reg[AW-1:0];
                    mem_wdata = {hdr_sz, 1'b0};
                end
            end
            S_FNEXT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = t_reg[AW-1:0];
                mem_wdata  = {merged[SW-1:0], 1'b0};
                tsize_next = merged[SW-1:0];
            end
            S_FPRED:
            begin
                if (has_pred_reg && !prev_used_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prev_reg[AW-1:0];
                    mem_wdata = {pred_sum[SW-1:0], 1'b0};
                end
            end
            S_DONE:
            begin
                st.done = out_free;
            end
            default:
            begin
                st.idle = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        need_reg       <= need_next;
        t_reg          <= t_next;
        prev_reg       <= prev_next;
        prev_sz_reg    <= prev_sz_next;
        prev_used_reg  <= prev_used_next;
        has_pred_reg   <= has_pred_next;
        tsize_reg      <= tsize_next;
        split_addr_reg <= split_addr_next;
        split_sz_reg   <= split_sz_next;
        res_reg        <= res_next;
    end

endmodule
